[hw/rtl/scp_pkg.sv]
// Shared types, widths and command codes for the shape pair collision test.
// Used by every module under hw/rtl; depends on nothing else.
package scp_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 15;
   localparam int CMD_BITS   = 3;
   localparam int LANES      = 4;
   localparam int STAGES     = 4;

   localparam int MAG_BITS  = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
   localparam int PT_BITS   = MAG_BITS + 2;
   localparam int DIFF_BITS = PT_BITS + 1;
   localparam int RAD_BITS  = SIZE_BITS + 1;
   localparam int SQ_BITS   = 2 * DIFF_BITS;
   localparam int RSQ_BITS  = 2 * RAD_BITS;
   localparam int SUM_BITS  = SQ_BITS + 1;

   localparam logic [CMD_BITS-1:0] CMD_RECT_POINT    = CMD_BITS'(0);
   localparam logic [CMD_BITS-1:0] CMD_CIRCLE_POINT  = CMD_BITS'(1);
   localparam logic [CMD_BITS-1:0] CMD_RECT_RECT     = CMD_BITS'(2);
   localparam logic [CMD_BITS-1:0] CMD_CIRCLE_CIRCLE = CMD_BITS'(3);
   localparam logic [CMD_BITS-1:0] CMD_CIRCLE_RECT   = CMD_BITS'(4);

   typedef logic signed [PT_BITS-1:0]   pt_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]          command;
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic [SIZE_BITS-1:0]         a_w;
      logic [SIZE_BITS-1:0]         a_h;
      logic                         a_collide;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic [SIZE_BITS-1:0]         b_w;
      logic [SIZE_BITS-1:0]         b_h;
      logic                         b_collide;
   } req_type;

   typedef struct packed {
      logic hit;
      logic a_collide_out;
      logic b_collide_out;
   } rsp_type;

   // Stage 1: corner and extreme points, rectangle edges, radius
   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic                  a_collide;
      logic                  b_collide;
      logic                  circle_pair;
      pt_type                cx;
      pt_type                cy;
      logic [RAD_BITS-1:0]   rad;
      pt_type                rect_l;
      pt_type                rect_t;
      pt_type                rect_r;
      pt_type                rect_b;
      pt_type [LANES-1:0]    rpx;
      pt_type [LANES-1:0]    rpy;
      pt_type [LANES-1:0]    cpx;
      pt_type [LANES-1:0]    cpy;
   } s1_type;

   // Stage 2: rectangle verdict, circle offsets and box checks
   typedef struct packed {
      logic [CMD_BITS-1:0]   command;
      logic                  a_collide;
      logic                  b_collide;
      logic                  circle_pair;
      logic                  rect_hit;
      logic [LANES-1:0]      box;
      diff_type [LANES-1:0]  dx;
      diff_type [LANES-1:0]  dy;
      logic [RAD_BITS-1:0]   rad;
   } s2_type;

   // Stage 3: squared offsets and squared radius
   typedef struct packed {
      logic [CMD_BITS-1:0]              command;
      logic                             a_collide;
      logic                             b_collide;
      logic                             circle_pair;
      logic                             rect_hit;
      logic [LANES-1:0]                 box;
      logic [LANES-1:0][SQ_BITS-1:0]    dx2;
      logic [LANES-1:0][SQ_BITS-1:0]    dy2;
      logic [RSQ_BITS-1:0]              rsq;
   } s3_type;

   function automatic pt_type ext_coord(input logic signed [COORD_BITS-1:0] c);
      return $signed({{(PT_BITS-COORD_BITS){c[COORD_BITS-1]}}, c});
   endfunction

   function automatic pt_type ext_size(input logic [SIZE_BITS-1:0] s);
      return $signed({{(PT_BITS-SIZE_BITS){1'b0}}, s});
   endfunction

endpackage

[hw/rtl/scp_front.sv]
// First two pipeline stages: test points and edges, then offsets, box checks
// and the rectangle verdict. Depends on scp_pkg.
module scp_front (
   input  logic            clock,
   input  logic [1:0]      load,
   input  scp_pkg::req_type req,
   output scp_pkg::s2_type  s2
);

   scp_pkg::s1_type   s1_in, s1_ff;
   scp_pkg::s2_type   s2_in, s2_ff;
   scp_pkg::pt_type   ax, ay, aw, ah, bx, by, bw, bh, bxr, byb;
   logic [scp_pkg::LANES-1:0] rect_lane;
   scp_pkg::diff_type rad_s;

   always_comb begin
      ax  = scp_pkg::ext_coord(req.a_x);
      ay  = scp_pkg::ext_coord(req.a_y);
      aw  = scp_pkg::ext_size(req.a_w);
      ah  = scp_pkg::ext_size(req.a_h);
      bx  = scp_pkg::ext_coord(req.b_x);
      by  = scp_pkg::ext_coord(req.b_y);
      bw  = scp_pkg::ext_size(req.b_w);
      bh  = scp_pkg::ext_size(req.b_h);
      bxr = bx + bw;
      byb = by + bh;

      s1_in.command     = req.command;
      s1_in.a_collide   = req.a_collide;
      s1_in.b_collide   = req.b_collide;
      s1_in.circle_pair = (req.command == scp_pkg::CMD_CIRCLE_CIRCLE);
      s1_in.cx          = ax;
      s1_in.cy          = ay;
      if (req.command == scp_pkg::CMD_CIRCLE_CIRCLE) begin
         s1_in.rad = scp_pkg::RAD_BITS'(req.a_w) + scp_pkg::RAD_BITS'(req.b_w);
      end else begin
         s1_in.rad = scp_pkg::RAD_BITS'(req.a_w);
      end

      // corners of b, clockwise from top-left
      s1_in.cpx[0] = bx;  s1_in.cpy[0] = by;
      s1_in.cpx[1] = bxr; s1_in.cpy[1] = by;
      s1_in.cpx[2] = bxr; s1_in.cpy[2] = byb;
      s1_in.cpx[3] = bx;  s1_in.cpy[3] = byb;

      if (req.command == scp_pkg::CMD_CIRCLE_RECT) begin
         // extremes of circle a against rectangle b
         s1_in.rect_l = bx;
         s1_in.rect_t = by;
         s1_in.rect_r = bxr;
         s1_in.rect_b = byb;
         s1_in.rpx[0] = ax + aw; s1_in.rpy[0] = ay;
         s1_in.rpx[1] = ax - aw; s1_in.rpy[1] = ay;
         s1_in.rpx[2] = ax;      s1_in.rpy[2] = ay + aw;
         s1_in.rpx[3] = ax;      s1_in.rpy[3] = ay - aw;
      end else begin
         s1_in.rect_l = ax;
         s1_in.rect_t = ay;
         s1_in.rect_r = ax + aw;
         s1_in.rect_b = ay + ah;
         s1_in.rpx    = s1_in.cpx;
         s1_in.rpy    = s1_in.cpy;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         s1_ff <= s1_in;
      end
   end

   always_comb begin
      rad_s = scp_pkg::DIFF_BITS'($signed({1'b0, s1_ff.rad}));
      s2_in.command     = s1_ff.command;
      s2_in.a_collide   = s1_ff.a_collide;
      s2_in.b_collide   = s1_ff.b_collide;
      s2_in.circle_pair = s1_ff.circle_pair;
      s2_in.rad         = s1_ff.rad;
      for (int i = 0; i < scp_pkg::LANES; i++) begin
         rect_lane[i] = ($signed(s1_ff.rpx[i]) >= $signed(s1_ff.rect_l))
                     && ($signed(s1_ff.rpx[i]) <= $signed(s1_ff.rect_r))
                     && ($signed(s1_ff.rpy[i]) >= $signed(s1_ff.rect_t))
                     && ($signed(s1_ff.rpy[i]) <= $signed(s1_ff.rect_b));
         s2_in.dx[i] = scp_pkg::DIFF_BITS'($signed(s1_ff.cx))
                     - scp_pkg::DIFF_BITS'($signed(s1_ff.cpx[i]));
         s2_in.dy[i] = scp_pkg::DIFF_BITS'($signed(s1_ff.cy))
                     - scp_pkg::DIFF_BITS'($signed(s1_ff.cpy[i]));
         // circle pair is strict in y only
         if (s1_ff.circle_pair) begin
            s2_in.box[i] = ($signed(s2_in.dx[i]) >= -rad_s)
                        && ($signed(s2_in.dx[i]) <= rad_s)
                        && ($signed(s2_in.dy[i]) > -rad_s)
                        && ($signed(s2_in.dy[i]) < rad_s);
         end else begin
            s2_in.box[i] = ($signed(s2_in.dx[i]) >= -rad_s)
                        && ($signed(s2_in.dx[i]) <= rad_s)
                        && ($signed(s2_in.dy[i]) >= -rad_s)
                        && ($signed(s2_in.dy[i]) <= rad_s);
         end
      end
      if (s1_ff.command == scp_pkg::CMD_RECT_POINT) begin
         s2_in.rect_hit = rect_lane[0];
      end else begin
         s2_in.rect_hit = |rect_lane;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         s2_ff <= s2_in;
      end
   end

   assign s2 = s2_ff;

endmodule

[hw/rtl/scp_square.sv]
// Third pipeline stage: squares the circle offsets and the radius.
// Depends on scp_pkg.
module scp_square (
   input  logic            clock,
   input  logic            load,
   input  scp_pkg::s2_type s2,
   output scp_pkg::s3_type s3
);

   scp_pkg::s3_type s3_in, s3_ff;
   logic signed [scp_pkg::SQ_BITS-1:0] sq_x [scp_pkg::LANES];
   logic signed [scp_pkg::SQ_BITS-1:0] sq_y [scp_pkg::LANES];

   always_comb begin
      s3_in.command     = s2.command;
      s3_in.a_collide   = s2.a_collide;
      s3_in.b_collide   = s2.b_collide;
      s3_in.circle_pair = s2.circle_pair;
      s3_in.rect_hit    = s2.rect_hit;
      s3_in.box         = s2.box;
      for (int i = 0; i < scp_pkg::LANES; i++) begin
         sq_x[i] = scp_pkg::SQ_BITS'($signed(s2.dx[i]))
                 * scp_pkg::SQ_BITS'($signed(s2.dx[i]));
         sq_y[i] = scp_pkg::SQ_BITS'($signed(s2.dy[i]))
                 * scp_pkg::SQ_BITS'($signed(s2.dy[i]));
         s3_in.dx2[i] = $unsigned(sq_x[i]);
         s3_in.dy2[i] = $unsigned(sq_y[i]);
      end
      s3_in.rsq = scp_pkg::RSQ_BITS'(s2.rad) * scp_pkg::RSQ_BITS'(s2.rad);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s3_ff <= s3_in;
      end
   end

   assign s3 = s3_ff;

endmodule

[hw/rtl/scp_decide.sv]
// Last pipeline stage: distance compares, per-command verdict, flag update
// and the result register. Depends on scp_pkg.
module scp_decide (
   input  logic             clock,
   input  logic             load,
   input  scp_pkg::s3_type  s3,
   output scp_pkg::rsp_type rsp
);

   scp_pkg::rsp_type rsp_in, rsp_ff;
   logic [scp_pkg::SUM_BITS-1:0] dist_sq [scp_pkg::LANES];
   logic [scp_pkg::SUM_BITS-1:0] rsq_ext;
   logic [scp_pkg::LANES-1:0]    circ_ok;
   logic                         pair_ok;
   logic                         pair_cmd;

   always_comb begin
      rsq_ext = scp_pkg::SUM_BITS'(s3.rsq);
      for (int i = 0; i < scp_pkg::LANES; i++) begin
         dist_sq[i] = scp_pkg::SUM_BITS'(s3.dx2[i]) + scp_pkg::SUM_BITS'(s3.dy2[i]);
         if (s3.circle_pair) begin
            circ_ok[i] = s3.box[i] && (dist_sq[i] < rsq_ext);
         end else begin
            circ_ok[i] = s3.box[i] && (dist_sq[i] <= rsq_ext);
         end
      end
      pair_ok  = !(s3.a_collide && s3.b_collide);
      pair_cmd = 1'b0;
      case (s3.command)
         scp_pkg::CMD_RECT_POINT: begin
            rsp_in.hit = s3.rect_hit;
         end
         scp_pkg::CMD_CIRCLE_POINT: begin
            rsp_in.hit = circ_ok[0];
         end
         scp_pkg::CMD_RECT_RECT: begin
            pair_cmd   = 1'b1;
            rsp_in.hit = pair_ok && s3.rect_hit;
         end
         scp_pkg::CMD_CIRCLE_CIRCLE: begin
            pair_cmd   = 1'b1;
            rsp_in.hit = pair_ok && circ_ok[0];
         end
         scp_pkg::CMD_CIRCLE_RECT: begin
            pair_cmd   = 1'b1;
            rsp_in.hit = pair_ok && ((|circ_ok) || s3.rect_hit);
         end
         default: begin
            rsp_in.hit = 1'b0;
         end
      endcase
      // a pair hit marks both shapes; point tests leave the flags alone
      rsp_in.a_collide_out = s3.a_collide || (pair_cmd && rsp_in.hit);
      rsp_in.b_collide_out = s3.b_collide || (pair_cmd && rsp_in.hit);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

[hw/rtl/shape_pair_collision_test.sv]
// Shape pair collision test: a four-stage pipeline that takes one test per
// cycle unless stalled and returns one result per test, in order, through
// its registers (points and edges, offsets and box checks, squaring, compare
// and result register). Sustained rate is one item per clock unless stalled;
// the figure is set by the squaring stage, which runs four lanes of offset
// squares in parallel so even the eight-point circle-rectangle test needs a
// single pass. Ready depends only on the result side and the stage valid
// bits, so a stalled consumer fills the stages before the input stalls.
module shape_pair_collision_test (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scp_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output scp_pkg::rsp_type rsp
);

   logic [scp_pkg::STAGES-1:0] valid_ff, valid_in, upstream;
   logic [scp_pkg::STAGES:0]   load;
   scp_pkg::s2_type            s2;
   scp_pkg::s3_type            s3;

   // a stage may load when it is empty or its contents move on
   always_comb begin
      load[scp_pkg::STAGES] = rsp_ready;
      for (int k = scp_pkg::STAGES - 1; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      upstream = {valid_ff[scp_pkg::STAGES-2:0], req_valid};
      valid_in = (upstream & load[scp_pkg::STAGES-1:0])
               | (valid_ff & ~load[scp_pkg::STAGES-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[scp_pkg::STAGES-1];

   scp_front u_front (
      .clock (clock),
      .load  (load[1:0]),
      .req   (req),
      .s2    (s2)
   );

   scp_square u_square (
      .clock (clock),
      .load  (load[2]),
      .s2    (s2),
      .s3    (s3)
   );

   scp_decide u_decide (
      .clock (clock),
      .load  (load[3]),
      .s3    (s3),
      .rsp   (rsp)
   );

endmodule

[hw/rtl/scp_checker.sv]
// Port-level checks for shape_pair_collision_test, attached by bind.
// Depends on scp_pkg and the top level's port list.
module scp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input scp_pkg::req_type req,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input scp_pkg::rsp_type rsp
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty or draining result register never blocks the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with result side free");

   // with the consumer ready, a point test comes back with its flag unchanged
   a_point_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req.command == scp_pkg::CMD_RECT_POINT
      ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
      |=> rsp_valid && (rsp.a_collide_out == $past(req.a_collide, 4)))
      else $error("point test result late or flag altered");

endmodule

bind shape_pair_collision_test scp_checker u_scp_checker (.*);

[bench/scp_collision_checker.sv]
// Checker for the shape pair collision test: predicts each result from the
// accepted request and compares it with the block's responses, in order.
// Depends on scp_pkg for the request/response types and command codes.
module scp_collision_checker
   import scp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp,
   output int      mismatch_count,
   output int      results_waiting
);

   localparam int REPORT_LIMIT = 10;

   rsp_type expected_flags_q[$];
   int      errors = 0;

   function automatic bit point_in_box(input longint l, t, w, h, px, py);
      return px >= l && px <= l + w && py >= t && py <= t + h;
   endfunction

   function automatic bit point_in_disc(input longint cx, cy, r, px, py);
      longint dx, dy;
      // bounding box first, then the exact squared distance
      if (px < cx - r || px > cx + r || py < cy - r || py > cy + r)
         return 1'b0;
      dx = cx - px;
      dy = cy - py;
      return dx * dx + dy * dy <= r * r;
   endfunction

   function automatic rsp_type predict_collision(input req_type r);
      longint  ax, ay, aw, ah, bx, by, bw, bh, rs, dx, dy;
      bit      hit;
      bit      pair_free;
      bit      pair_cmd;
      rsp_type e;
      ax = longint'($signed(r.a_x));
      ay = longint'($signed(r.a_y));
      bx = longint'($signed(r.b_x));
      by = longint'($signed(r.b_y));
      aw = longint'(r.a_w);
      ah = longint'(r.a_h);
      bw = longint'(r.b_w);
      bh = longint'(r.b_h);
      hit = 1'b0;
      pair_free = !(r.a_collide && r.b_collide);
      pair_cmd = r.command == CMD_RECT_RECT || r.command == CMD_CIRCLE_CIRCLE ||
                 r.command == CMD_CIRCLE_RECT;
      case (r.command)
         CMD_RECT_POINT: hit = point_in_box(ax, ay, aw, ah, bx, by);
         CMD_CIRCLE_POINT: hit = point_in_disc(ax, ay, aw, bx, by);
         CMD_RECT_RECT: begin
            if (pair_free)
               hit = point_in_box(ax, ay, aw, ah, bx, by) ||
                     point_in_box(ax, ay, aw, ah, bx + bw, by) ||
                     point_in_box(ax, ay, aw, ah, bx + bw, by + bh) ||
                     point_in_box(ax, ay, aw, ah, bx, by + bh);
         end
         CMD_CIRCLE_CIRCLE: begin
            rs = aw + bw;
            dx = ax - bx;
            dy = ay - by;
            // non-strict in x, strict in y and on the distance
            if (pair_free && (dx < 0 ? -dx : dx) <= rs && (dy < 0 ? -dy : dy) < rs)
               hit = dx * dx + dy * dy < rs * rs;
         end
         CMD_CIRCLE_RECT: begin
            if (pair_free)
               hit = point_in_disc(ax, ay, aw, bx, by) ||
                     point_in_disc(ax, ay, aw, bx + bw, by) ||
                     point_in_disc(ax, ay, aw, bx + bw, by + bh) ||
                     point_in_disc(ax, ay, aw, bx, by + bh) ||
                     point_in_box(bx, by, bw, bh, ax + aw, ay) ||
                     point_in_box(bx, by, bw, bh, ax - aw, ay) ||
                     point_in_box(bx, by, bw, bh, ax, ay + aw) ||
                     point_in_box(bx, by, bw, bh, ax, ay - aw);
         end
         default: ;
      endcase
      e.hit           = hit;
      e.a_collide_out = r.a_collide || (hit && pair_cmd);
      e.b_collide_out = r.b_collide || (hit && pair_cmd);
      return e;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_flags_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_flags_q.push_back(predict_collision(req));
         if (rsp_valid && rsp_ready) begin
            if (expected_flags_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("unexpected result: hit=%0b a_collide=%0b b_collide=%0b",
                           rsp.hit, rsp.a_collide_out, rsp.b_collide_out);
            end else begin
               want = expected_flags_q.pop_front();
               if (rsp.hit !== want.hit || rsp.a_collide_out !== want.a_collide_out ||
                   rsp.b_collide_out !== want.b_collide_out) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("result mismatch: expected hit=%0b a=%0b b=%0b, got hit=%0b a=%0b b=%0b",
                              want.hit, want.a_collide_out, want.b_collide_out,
                              rsp.hit, rsp.a_collide_out, rsp.b_collide_out);
               end
            end
         end
      end
      mismatch_count  <= errors;
      results_waiting <= expected_flags_q.size();
   end

endmodule

[bench/tb_shape_pair_collision_test.sv]
// Testbench top for the shape pair collision test: clock, reset, request
// stimulus with idle phases, response back-pressure, watchdog and verdict.
// Depends on scp_pkg, shape_pair_collision_test and scp_collision_checker.
module tb_shape_pair_collision_test;
   import scp_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 500;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp;

   int          mismatch_count;
   int          results_waiting;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          quiet_cycles   = 0;

   always #5 clock = ~clock;

   shape_pair_collision_test dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   scp_collision_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp),
      .mismatch_count  (mismatch_count),
      .results_waiting (results_waiting)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_type make_pair(input logic [CMD_BITS-1:0] cmd,
                                         input int ax, ay, aw, ah, ac,
                                         input int bx, by, bw, bh, bc);
      req_type r;
      r.command   = cmd;
      r.a_x       = COORD_BITS'(ax);
      r.a_y       = COORD_BITS'(ay);
      r.a_w       = SIZE_BITS'(aw);
      r.a_h       = SIZE_BITS'(ah);
      r.a_collide = 1'(ac);
      r.b_x       = COORD_BITS'(bx);
      r.b_y       = COORD_BITS'(by);
      r.b_w       = SIZE_BITS'(bw);
      r.b_h       = SIZE_BITS'(bh);
      r.b_collide = 1'(bc);
      return r;
   endfunction

   function automatic req_type random_shape_pair();
      req_type     r;
      int unsigned sel;
      int unsigned span;
      int unsigned reach;
      int unsigned base_x;
      int unsigned base_y;
      sel = $urandom_range(99);
      if (sel < 6)
         r.command = CMD_BITS'($urandom_range(2**CMD_BITS - 1, CMD_CIRCLE_RECT + 1));
      else
         r.command = CMD_BITS'($urandom_range(CMD_CIRCLE_RECT, CMD_RECT_POINT));
      r.a_collide = 1'($urandom_range(1));
      r.b_collide = 1'($urandom_range(1));
      if ($urandom_range(99) < 15) begin
         // noise: any coordinates and sizes at all
         r.a_x = COORD_BITS'($urandom);
         r.a_y = COORD_BITS'($urandom);
         r.b_x = COORD_BITS'($urandom);
         r.b_y = COORD_BITS'($urandom);
         r.a_w = SIZE_BITS'($urandom);
         r.a_h = SIZE_BITS'($urandom);
         r.b_w = SIZE_BITS'($urandom);
         r.b_h = SIZE_BITS'($urandom);
      end else begin
         // mostly small shapes placed close together, so hits and misses mix
         sel = $urandom_range(99);
         span = (sel < 50) ? 15 : (sel < 80) ? 255 : (sel < 95) ? 4095 : 32767;
         reach = 2 * span + 8;
         base_x = $urandom;
         base_y = $urandom;
         r.a_w = SIZE_BITS'($urandom_range(span));
         r.a_h = SIZE_BITS'($urandom_range(span));
         r.b_w = SIZE_BITS'($urandom_range(span));
         r.b_h = SIZE_BITS'($urandom_range(span));
         r.a_x = COORD_BITS'(base_x);
         r.a_y = COORD_BITS'(base_y);
         r.b_x = COORD_BITS'(base_x + $urandom_range(2 * reach) - reach);
         r.b_y = COORD_BITS'(base_y + $urandom_range(2 * reach) - reach);
      end
      return r;
   endfunction

   task automatic send_pair(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req       <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Hold off the sender until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // rectangle-point: inclusive far corner, one past it, extremes
      send_pair(make_pair(CMD_RECT_POINT, 10, 20, 30, 40, 0, 40, 60, 0, 0, 0));
      send_pair(make_pair(CMD_RECT_POINT, 10, 20, 30, 40, 0, 41, 60, 0, 0, 0));
      send_pair(make_pair(CMD_RECT_POINT, -32768, -32768, 32767, 32767, 1,
                          -1, -1, 0, 0, 1));
      send_pair(make_pair(CMD_RECT_POINT, 32767, 32767, 32767, 32767, 0,
                          32767, 32767, 32767, 32767, 0));
      // circle-point: on the circle, in the box but outside, zero radius
      send_pair(make_pair(CMD_CIRCLE_POINT, 0, 0, 5, 0, 0, 3, 4, 0, 0, 0));
      send_pair(make_pair(CMD_CIRCLE_POINT, 0, 0, 5, 0, 0, 4, 4, 0, 0, 0));
      send_pair(make_pair(CMD_CIRCLE_POINT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1));
      send_pair(make_pair(CMD_CIRCLE_POINT, -32768, 32767, 32767, 32767, 0,
                          32767, -32768, 32767, 32767, 1));
      // rectangle-rectangle: touching corners, near miss, one flag set, both set
      send_pair(make_pair(CMD_RECT_RECT, 0, 0, 10, 10, 0, 10, 10, 5, 5, 0));
      send_pair(make_pair(CMD_RECT_RECT, 0, 0, 10, 10, 0, -5, -5, 4, 4, 0));
      send_pair(make_pair(CMD_RECT_RECT, 0, 0, 10, 10, 1, -5, -5, 5, 5, 0));
      send_pair(make_pair(CMD_RECT_RECT, 0, 0, 10, 10, 1, 2, 2, 3, 3, 1));
      // circle-circle: touching in x, touching in y, overlap, skipped
      send_pair(make_pair(CMD_CIRCLE_CIRCLE, 0, 0, 3, 0, 0, 7, 0, 4, 0, 0));
      send_pair(make_pair(CMD_CIRCLE_CIRCLE, 0, 0, 3, 0, 0, 0, 7, 4, 0, 0));
      send_pair(make_pair(CMD_CIRCLE_CIRCLE, 0, 0, 3, 0, 0, 6, 0, 4, 0, 1));
      send_pair(make_pair(CMD_CIRCLE_CIRCLE, 0, 0, 3, 0, 1, 1, 1, 4, 0, 1));
      send_pair(make_pair(CMD_CIRCLE_CIRCLE, -32768, -32768, 32767, 32767, 0,
                          32767, 32767, 32767, 32767, 0));
      send_pair(make_pair(CMD_CIRCLE_CIRCLE, -32768, 0, 32767, 0, 0,
                          32766, 0, 32767, 0, 0));
      // circle-rectangle: corner in circle, circle inside rectangle, miss, skipped
      send_pair(make_pair(CMD_CIRCLE_RECT, 0, 0, 10, 0, 0, 7, 7, 20, 20, 0));
      send_pair(make_pair(CMD_CIRCLE_RECT, 50, 50, 5, 0, 0, 0, 0, 100, 100, 0));
      send_pair(make_pair(CMD_CIRCLE_RECT, 0, 0, 10, 0, 0, 8, 8, 5, 5, 0));
      send_pair(make_pair(CMD_CIRCLE_RECT, 0, 0, 10, 0, 1, 0, 0, 5, 5, 1));
      send_pair(make_pair(CMD_CIRCLE_RECT, 32767, -32768, 32767, 32767, 0,
                          -32768, 32767, 32767, 32767, 0));
      // unused command codes
      send_pair(make_pair(CMD_BITS'(CMD_CIRCLE_RECT + 1), 0, 0, 10, 10, 1,
                          0, 0, 10, 10, 0));
      send_pair(make_pair(CMD_BITS'(CMD_CIRCLE_RECT + 2), 0, 0, 10, 10, 0,
                          0, 0, 10, 10, 1));
      send_pair(make_pair(CMD_BITS'(2**CMD_BITS - 1), -1, -1, 32767, 32767, 1,
                          -1, -1, 32767, 32767, 1));
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         repeat (PHASE_ITEMS) send_pair(random_shape_pair());
         drain_results();
      end

      repeat (STAGES + 4) @(posedge clock);
      if (mismatch_count == 0 && results_waiting == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
